// File: hw/rtl/mrrc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the response checker.
package mrrc_pkg;

  // Default payload buffer depth in bytes
  localparam int unsigned MAX_DATA_BYTES_DEF = 32;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned REG_CNT_W = 5;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned FRAMES_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_VALUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT   = 3'd5;

  // Frame format select
  localparam logic MODE_ECHO = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_EXC = 1'b1;

  // Exception replies carry the function code plus 0x80 (bit 7 flipped)
  localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Parser states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_FUNC   = 12'b0000_0000_0010,
    ST_REGHI  = 12'b0000_0000_0100,
    ST_REGLO  = 12'b0000_0000_1000,
    ST_VALHI  = 12'b0000_0001_0000,
    ST_VALLO  = 12'b0000_0010_0000,
    ST_ECRCLO = 12'b0000_0100_0000,
    ST_ECRCHI = 12'b0000_1000_0000,
    ST_COUNT  = 12'b0001_0000_0000,
    ST_DATA   = 12'b0010_0000_0000,
    ST_RCRCLO = 12'b0100_0000_0000,
    ST_RCRCHI = 12'b1000_0000_0000
  } mrrc_state_e;

  // Reflected CRC update over one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mrrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered, enabled read.
module mrrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/modbus_rtu_response_checker_top.sv
// Modbus RTU response checker: top level with parser, payload buffer and result run.
//
// Received bytes enter through an input register and are parsed one per cycle when
// not held: the parser checks address, function code, echo fields or byte count,
// updates the CRC-16/MODBUS one byte per cycle and checks the CRC low byte first. A
// bad byte silently drops the frame. An exception reply (function code plus 0x80,
// i.e. bit 7 flipped) gives one result with status 1. An accepted echo frame, or a
// read frame with a zero byte count, gives one result. An accepted read frame of N
// data bytes gives a run of N results, one per cycle while the result register has
// room, read back last byte first from the payload RAM; the run is paced by that
// RAM's single read port, and while it drains the parser holds the next byte in its
// input register (one more byte is taken in). Single results are registered directly,
// run words via the RAM read and pend_q. Outside of runs, a byte is taken every cycle
// as long as the result register is free or being emptied. There is no clearing pass
// after reset. The user must write configuration only while idle; it is not enforced.
module modbus_rtu_response_checker_top #(
  parameter int unsigned MaxDataBytes = mrrc_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [mrrc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mrrc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // received byte stream
  input  logic                                 rx_valid_i,
  output logic                                 rx_ready_o,
  input  logic [mrrc_pkg::BYTE_W-1:0]          rx_byte_i,
  // results
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic                                 status_o,
  output logic [mrrc_pkg::BYTE_W-1:0]          data_byte_o,
  output logic [mrrc_pkg::INDEX_W-1:0]         data_index_o,
  output logic [mrrc_pkg::FRAMES_W-1:0]        frame_count_o,
  output logic                                 last_o
);

  import mrrc_pkg::*;

  localparam int unsigned AW = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
  localparam int unsigned CW = $clog2(MaxDataBytes + 1);

  // Configuration registers
  logic                  mode_q;
  logic [BYTE_W-1:0]     slave_q;
  logic [BYTE_W-1:0]     func_q;
  logic [15:0]           reg_addr_q;
  logic [15:0]           echo_q;
  logic [REG_CNT_W-1:0]  reg_cnt_q;

  // Input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] rx_q;

  // Parser state
  mrrc_state_e         state_q, state_d;
  logic [15:0]         crc_q, crc_d, crc_upd;
  logic [CW-1:0]       counter_q, counter_d, counter_nxt;
  logic [CW-1:0]       bcnt_q, bcnt_d;
  logic [FRAMES_W-1:0] frames_q, frames_d;

  // Run reader
  logic                run_q;
  logic [AW-1:0]       rd_addr_q;
  logic [INDEX_W-1:0]  rd_idx_q;
  logic [CW-1:0]       rd_left_q;
  logic                pend_q;
  logic [INDEX_W-1:0]  pend_idx_q;
  logic                pend_last_q;
  logic                issue, move;
  logic [BYTE_W-1:0]   ram_rdata;

  // Output register
  logic                out_valid_q;
  logic                status_q;
  logic [BYTE_W-1:0]   data_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [FRAMES_W-1:0] fc_q;
  logic                last_q;

  logic out_free, proc_fire, rx_fire;
  logic emit, emit_status, start_run, ram_we, count_ok;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ECHO;
      slave_q    <= 8'd1;
      func_q     <= 8'd3;
      reg_addr_q <= '0;
      echo_q     <= '0;
      reg_cnt_q  <= REG_CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q     <= cfg_data_i[0];
        CFG_SLAVE_ADDR: slave_q    <= cfg_data_i[BYTE_W-1:0];
        CFG_FUNC_CODE:  func_q     <= cfg_data_i[BYTE_W-1:0];
        CFG_REG_ADDR:   reg_addr_q <= cfg_data_i;
        CFG_ECHO_VALUE: echo_q     <= cfg_data_i;
        CFG_REG_COUNT:  reg_cnt_q  <= cfg_data_i[REG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: parse a byte only with no run pending and room in the result register
  assign out_free   = !out_valid_q || res_ready_i;
  assign proc_fire  = in_valid_q && !run_q && !pend_q && out_free;
  assign rx_ready_o = !in_valid_q || proc_fire;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      rx_q <= rx_byte_i;
    end
  end

  assign crc_upd     = crc16_byte(crc_q, rx_q);
  assign counter_nxt = counter_q + 1'b1;
  assign count_ok    = (rx_q == {2'b00, reg_cnt_q, 1'b0}) &&
                       (rx_q <= BYTE_W'(MaxDataBytes));

  // Frame parser
  always_comb begin
    state_d     = state_q;
    crc_d       = crc_q;
    counter_d   = counter_q;
    bcnt_d      = bcnt_q;
    frames_d    = frames_q;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    start_run   = 1'b0;
    ram_we      = 1'b0;
    if (proc_fire) begin
      case (state_q)
        ST_IDLE: begin
          if (rx_q == slave_q) begin
            crc_d   = crc16_byte(CRC_INIT, rx_q);
            state_d = ST_FUNC;
          end
        end
        ST_FUNC: begin
          state_d = ST_IDLE;
          if (rx_q == func_q) begin
            crc_d   = crc_upd;
            state_d = (mode_q == MODE_READ) ? ST_COUNT : ST_REGHI;
          end else if (rx_q == BYTE_W'(func_q + EXC_FLAG)) begin
            emit        = 1'b1;
            emit_status = STATUS_EXC;
          end
        end
        ST_REGHI: begin
          state_d = ST_IDLE;
          if (rx_q == reg_addr_q[15:8]) begin
            crc_d   = crc_upd;
            state_d = ST_REGLO;
          end
        end
        ST_REGLO: begin
          state_d = ST_IDLE;
          if (rx_q == reg_addr_q[7:0]) begin
            crc_d   = crc_upd;
            state_d = ST_VALHI;
          end
        end
        ST_VALHI: begin
          state_d = ST_IDLE;
          if (rx_q == echo_q[15:8]) begin
            crc_d   = crc_upd;
            state_d = ST_VALLO;
          end
        end
        ST_VALLO: begin
          state_d = ST_IDLE;
          if (rx_q == echo_q[7:0]) begin
            crc_d   = crc_upd;
            state_d = ST_ECRCLO;
          end
        end
        ST_ECRCLO: begin
          state_d = (rx_q == crc_q[7:0]) ? ST_ECRCHI : ST_IDLE;
        end
        ST_RCRCLO: begin
          state_d = (rx_q == crc_q[7:0]) ? ST_RCRCHI : ST_IDLE;
        end
        ST_ECRCHI: begin
          state_d = ST_IDLE;
          if (rx_q == crc_q[15:8]) begin
            frames_d = frames_q + 1'b1;
            emit     = 1'b1;
          end
        end
        ST_COUNT: begin
          state_d = ST_IDLE;
          if (count_ok) begin
            crc_d     = crc_upd;
            bcnt_d    = rx_q[CW-1:0];
            counter_d = '0;
            state_d   = (rx_q == '0) ? ST_RCRCLO : ST_DATA;
          end
        end
        ST_DATA: begin
          ram_we    = 1'b1;
          crc_d     = crc_upd;
          counter_d = counter_nxt;
          if (counter_nxt >= bcnt_q) begin
            state_d = ST_RCRCLO;
          end
        end
        ST_RCRCHI: begin
          state_d = ST_IDLE;
          if (rx_q == crc_q[15:8]) begin
            frames_d = frames_q + 1'b1;
            if (bcnt_q == '0) begin
              emit = 1'b1;
            end else begin
              start_run = 1'b1;
            end
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      crc_q     <= CRC_INIT;
      counter_q <= '0;
      bcnt_q    <= '0;
      frames_q  <= '0;
    end else begin
      state_q   <= state_d;
      crc_q     <= crc_d;
      counter_q <= counter_d;
      bcnt_q    <= bcnt_d;
      frames_q  <= frames_d;
    end
  end

  // Payload buffer
  mrrc_ram #(
    .Width (BYTE_W),
    .Depth (MaxDataBytes)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (counter_q[AW-1:0]),
    .wdata_i (rx_q),
    .re_i    (issue),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Run reader: one RAM read per cycle while the result register has room, last stored
  // byte first; pend_q marks read data waiting for the result register
  assign move  = pend_q && out_free;
  assign issue = run_q && (!pend_q || move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (start_run) begin
        run_q <= 1'b1;
      end else if (issue && rd_left_q == CW'(1)) begin
        run_q <= 1'b0;
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      rd_addr_q <= AW'(bcnt_q - 1'b1);
      rd_idx_q  <= '0;
      rd_left_q <= bcnt_q;
    end else if (issue) begin
      rd_addr_q <= rd_addr_q - 1'b1;
      rd_idx_q  <= rd_idx_q + 1'b1;
      rd_left_q <= rd_left_q - 1'b1;
    end
    if (issue) begin
      pend_idx_q  <= rd_idx_q;
      pend_last_q <= (rd_left_q == CW'(1));
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit || move) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_status;
      data_q   <= '0;
      idx_q    <= '0;
      fc_q     <= frames_d;
      last_q   <= 1'b1;
    end else if (move) begin
      status_q <= STATUS_OK;
      data_q   <= ram_rdata;
      idx_q    <= pend_idx_q;
      fc_q     <= frames_q;
      last_q   <= pend_last_q;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_byte_o   = data_q;
  assign data_index_o  = idx_q;
  assign frame_count_o = fc_q;
  assign last_o        = last_q;

endmodule

// File: hw/rtl/mrrc_checker.sv
// Port-level checks on the response checker's result stream, bound to the top level.
module mrrc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_o,
  input logic                          res_ready_i,
  input logic                          status_o,
  input logic [mrrc_pkg::BYTE_W-1:0]   data_byte_o,
  input logic [mrrc_pkg::INDEX_W-1:0]  data_index_o,
  input logic [mrrc_pkg::FRAMES_W-1:0] frame_count_o,
  input logic                          last_o
);

  import mrrc_pkg::*;

  // A stalled result word holds its data, index, frame count and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(data_byte_o) &&
      $stable(data_index_o) && $stable(frame_count_o) && $stable(last_o))
    else $error("stalled result word changed");

  // Exception replies are single, empty results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == STATUS_EXC |->
      last_o && data_byte_o == '0 && data_index_o == '0)
    else $error("malformed exception result");

  // Nonzero run positions only come from accepted read frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && data_index_o != '0 |-> status_o == STATUS_OK)
    else $error("run position on exception result");

  // Within a run the frame count does not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_o |=> $stable(frame_count_o))
    else $error("frame count changed inside a run");

endmodule

bind modbus_rtu_response_checker_top mrrc_checker u_mrrc_checker (.*);
